// ----- rtl/i2c_master_bit_engine_core_defines.svh -----
// Assertion macros shared by the I2C bit engine RTL.
// No dependencies; pulled in by the files that carry assertions.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CB_ASSERT_IMPLIES(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CB_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ----- rtl/i2cb_pkg.sv -----
// Types, constants and helpers for the I2C master bit engine.
// No dependencies; imported by i2c_master_bit_engine_core.
`default_nettype none

package i2cb_pkg;

   localparam int DELAY_BITS     = 16;
   localparam int BYTE_BITS      = 8;
   localparam int CSR_WIDTH      = 16;
   localparam int BIT_COUNT_BITS = 4;

   localparam logic [CSR_WIDTH-1:0] BIT_DELAY_RESET  = CSR_WIDTH'(10);
   localparam logic [CSR_WIDTH-1:0] READ_DELAY_RESET = CSR_WIDTH'(50);
   localparam logic [CSR_WIDTH-1:0] ACK_DELAY_RESET  = CSR_WIDTH'(5);

   localparam logic [32:0] DELAY_MAX_WIDE = (33'd1 << DELAY_BITS) - 33'd1;

   typedef logic [DELAY_BITS-1:0] delay_type;

   typedef enum logic [1:0] {
      CSR_BIT_DELAY  = 2'd0,
      CSR_READ_DELAY = 2'd1,
      CSR_ACK_DELAY  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_START     = 3'd0,
      OP_STOP      = 3'd1,
      OP_WRITE     = 3'd2,
      OP_READ      = 3'd3,
      OP_SEND_ACK  = 3'd4,
      OP_RECV_ACK  = 3'd5
   } opcode_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_S1   = 4'd1,
      PH_S2   = 4'd2,
      PH_P1   = 4'd3,
      PH_P2   = 4'd4,
      PH_WD   = 4'd5,
      PH_WH   = 4'd6,
      PH_WL   = 4'd7,
      PH_RH   = 4'd8,
      PH_RL   = 4'd9,
      PH_AH   = 4'd10,
      PH_AL   = 4'd11,
      PH_KH   = 4'd12,
      PH_KL   = 4'd13,
      PH_END  = 4'd14,
      PH_FIN  = 4'd15
   } phase_type;

   // Zero counts as one tick; anything above the counter range saturates.
   function automatic delay_type clamp_delay(input logic [CSR_WIDTH-1:0] d);
      logic [32:0] wide;
      wide = 33'(d);
      if (wide == 33'd0) begin
         return delay_type'(1);
      end else if (wide > DELAY_MAX_WIDE) begin
         return DELAY_MAX_WIDE[DELAY_BITS-1:0];
      end else begin
         return wide[DELAY_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/i2c_master_bit_engine_core.sv -----
// I2C master bit engine: line sequencer with a registered response stage.
// Depends on i2cb_pkg and i2c_master_bit_engine_core_defines.svh.
`default_nettype none

// Each request transaction is one tick of I2C line timing. When req_cmd_valid
// is set and the engine is idle, the command in req_opcode starts (start,
// stop, write byte, read byte, send ack, receive ack); commands offered while
// busy, and unused opcodes, are dropped. Line changes are spaced by the
// bit_delay, read_delay and ack_delay registers (a zero counts as one tick).
// Every request transaction yields exactly one response transaction carrying
// the SCL/SDA drive levels and SDA direction after that tick, busy, a done
// pulse, the last read byte and the last received ack level. Throughput is one
// transaction per clock: the state update is a single pass of logic into the
// state registers, and the response register takes the new values in the same
// edge, so they appear in the cycle after the request; a stalled response holds
// req_ready low only while the response register is full and not taken.
// Write the csr_ registers only while no tick is in flight.
module i2c_master_bit_engine_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [i2cb_pkg::CSR_WIDTH-1:0] csr_write_data,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_cmd_valid,
   input  wire logic [2:0]                    req_opcode,
   input  wire logic [i2cb_pkg::BYTE_BITS-1:0] req_write_byte,
   input  wire logic                          req_ack_bit,
   input  wire logic                          req_sda_sample,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic                          rsp_scl_level,
   output      logic                          rsp_sda_level,
   output      logic                          rsp_sda_output_enable,
   output      logic                          rsp_busy_res,
   output      logic                          rsp_done_res,
   output      logic [i2cb_pkg::BYTE_BITS-1:0] rsp_read_byte,
   output      logic                          rsp_ack_seen
);
   import i2cb_pkg::*;
   `include "i2c_master_bit_engine_core_defines.svh"

   // Configuration registers.
   logic [CSR_WIDTH-1:0] bit_delay_ff, read_delay_ff, ack_delay_ff;

   // Line-sequencer state.
   phase_type                 phase_ff, phase_in;
   logic [2:0]                command_ff, command_in;
   delay_type                 delay_ff, delay_in;
   logic [BIT_COUNT_BITS-1:0] bit_count_ff, bit_count_in, bit_count_inc;
   logic [BYTE_BITS-1:0]      shift_ff, shift_in;
   logic [BYTE_BITS-1:0]      rd_result_ff, rd_result_in;
   logic                      scl_ff, scl_in;
   logic                      sda_ff, sda_in;
   logic                      sda_dir_ff, sda_dir_in;
   logic                      ack_ff, ack_in;
   logic                      done_in;

   // Response register.
   logic                 rsp_valid_ff;
   logic                 rsp_scl_ff, rsp_sda_ff, rsp_oe_ff, rsp_busy_ff, rsp_done_ff;
   logic                 rsp_ack_ff;
   logic [BYTE_BITS-1:0] rsp_read_byte_ff;

   logic tick;

   // Take a new tick whenever the response slot is empty or being emptied.
   assign req_ready     = !rsp_valid_ff || rsp_ready;
   assign tick          = req_valid && req_ready;
   assign bit_count_inc = bit_count_ff + BIT_COUNT_BITS'(1);

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_delay_ff  <= BIT_DELAY_RESET;
         read_delay_ff <= READ_DELAY_RESET;
         ack_delay_ff  <= ACK_DELAY_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BIT_DELAY:  bit_delay_ff  <= csr_write_data;
            CSR_READ_DELAY: read_delay_ff <= csr_write_data;
            CSR_ACK_DELAY:  ack_delay_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Next-state logic for one tick.
   always_comb begin
      phase_in     = phase_ff;
      command_in   = command_ff;
      delay_in     = delay_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      rd_result_in = rd_result_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      sda_dir_in   = sda_dir_ff;
      ack_in       = ack_ff;
      done_in      = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // Idle: launch a command if one is offered and the opcode is known.
         if (req_cmd_valid) begin
            unique case (req_opcode)
               OP_START: begin
                  command_in = req_opcode; bit_count_in = '0;
                  scl_in = 1'b1; sda_in = 1'b1; sda_dir_in = 1'b1;
                  phase_in = PH_S1; delay_in = clamp_delay(bit_delay_ff);
               end
               OP_STOP: begin
                  command_in = req_opcode; bit_count_in = '0;
                  scl_in = 1'b0; sda_in = 1'b0; sda_dir_in = 1'b1;
                  phase_in = PH_P1; delay_in = clamp_delay(bit_delay_ff);
               end
               OP_WRITE: begin
                  command_in = req_opcode; bit_count_in = '0;
                  scl_in = 1'b0; sda_dir_in = 1'b1; shift_in = req_write_byte;
                  phase_in = PH_WD; delay_in = clamp_delay(bit_delay_ff);
               end
               OP_READ: begin
                  command_in = req_opcode; bit_count_in = '0;
                  sda_dir_in = 1'b0; scl_in = 1'b0; shift_in = '0;
                  phase_in = PH_RH; delay_in = clamp_delay(read_delay_ff);
               end
               OP_SEND_ACK: begin
                  command_in = req_opcode; bit_count_in = '0;
                  scl_in = 1'b0; sda_in = req_ack_bit; sda_dir_in = 1'b1;
                  phase_in = PH_AH; delay_in = delay_type'(1);
               end
               OP_RECV_ACK: begin
                  command_in = req_opcode; bit_count_in = '0;
                  sda_dir_in = 1'b0; scl_in = 1'b0;
                  phase_in = PH_KH; delay_in = clamp_delay(read_delay_ff);
               end
               default: ;
            endcase
         end
      end else if (delay_ff > delay_type'(1)) begin
         delay_in = delay_ff - delay_type'(1);
      end else begin
         unique case (phase_ff)
            PH_S1: begin
               sda_in = 1'b0;
               phase_in = PH_S2; delay_in = clamp_delay(bit_delay_ff);
            end
            PH_S2: begin
               scl_in = 1'b0; phase_in = PH_IDLE; delay_in = '0; done_in = 1'b1;
            end
            PH_P1: begin
               scl_in = 1'b1;
               phase_in = PH_P2; delay_in = clamp_delay(bit_delay_ff);
            end
            PH_P2: begin
               sda_in = 1'b1;
               phase_in = PH_FIN; delay_in = clamp_delay(bit_delay_ff);
            end
            PH_WD: begin
               sda_in = shift_ff[BYTE_BITS-1];
               phase_in = PH_WH; delay_in = clamp_delay(bit_delay_ff);
            end
            PH_WH: begin
               scl_in = 1'b1;
               phase_in = PH_WL; delay_in = clamp_delay(bit_delay_ff);
            end
            PH_WL: begin
               scl_in       = 1'b0;
               shift_in     = {shift_ff[BYTE_BITS-2:0], 1'b0};
               bit_count_in = bit_count_inc;
               phase_in     = (bit_count_inc >= BIT_COUNT_BITS'(BYTE_BITS)) ? PH_FIN : PH_WD;
               delay_in     = clamp_delay(bit_delay_ff);
            end
            PH_RH: begin
               // Sample on the tick SCL rises; SCL then stays high one tick.
               scl_in   = 1'b1;
               shift_in = {shift_ff[BYTE_BITS-2:0], req_sda_sample};
               phase_in = PH_RL; delay_in = delay_type'(1);
            end
            PH_RL: begin
               scl_in       = 1'b0;
               bit_count_in = bit_count_inc;
               phase_in     = (bit_count_inc >= BIT_COUNT_BITS'(BYTE_BITS)) ? PH_END : PH_RH;
               delay_in     = clamp_delay(read_delay_ff);
            end
            PH_AH: begin
               scl_in = 1'b1;
               phase_in = PH_AL; delay_in = clamp_delay(ack_delay_ff);
            end
            PH_AL: begin
               scl_in = 1'b0;
               phase_in = PH_FIN; delay_in = clamp_delay(ack_delay_ff);
            end
            PH_KH: begin
               scl_in = 1'b1; ack_in = req_sda_sample;
               phase_in = PH_KL; delay_in = delay_type'(1);
            end
            PH_KL: begin
               scl_in = 1'b0;
               phase_in = PH_END; delay_in = clamp_delay(read_delay_ff);
            end
            PH_END: begin
               sda_dir_in = 1'b1;
               phase_in = PH_FIN; delay_in = clamp_delay(read_delay_ff);
            end
            default: begin
               // Final tick: publish a finished read and return to idle.
               if (command_ff == OP_READ) begin
                  rd_result_in = shift_ff;
               end
               phase_in = PH_IDLE; delay_in = '0; done_in = 1'b1;
            end
         endcase
      end
   end

   // Sequencer state advances only on an accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         command_ff   <= '0;
         delay_ff     <= '0;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         rd_result_ff <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         sda_dir_ff   <= 1'b1;
         ack_ff       <= 1'b1;
      end else if (tick) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         delay_ff     <= delay_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         rd_result_ff <= rd_result_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         sda_dir_ff   <= sda_dir_in;
         ack_ff       <= ack_in;
      end
   end

   // Response valid: set by a tick, cleared once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload: the state after the tick.
   always_ff @(posedge clock) begin
      if (tick) begin
         rsp_scl_ff       <= scl_in;
         rsp_sda_ff       <= sda_in;
         rsp_oe_ff        <= sda_dir_in;
         rsp_busy_ff      <= (phase_in != PH_IDLE);
         rsp_done_ff      <= done_in;
         rsp_read_byte_ff <= rd_result_in;
         rsp_ack_ff       <= ack_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_scl_level         = rsp_scl_ff;
   assign rsp_sda_level         = rsp_sda_ff;
   assign rsp_sda_output_enable = rsp_oe_ff;
   assign rsp_busy_res          = rsp_busy_ff;
   assign rsp_done_res          = rsp_done_ff;
   assign rsp_read_byte         = rsp_read_byte_ff;
   assign rsp_ack_seen          = rsp_ack_ff;

   `I2CB_ASSERT_NEXT(a_tick_gives_rsp, clock, reset, tick, rsp_valid_ff, "tick lost its response")
   `I2CB_ASSERT_IMPLIES(a_done_not_busy, clock, reset, rsp_valid_ff && rsp_done_ff, !rsp_busy_ff, "done while busy")
   `I2CB_ASSERT_IMPLIES(a_idle_no_delay, clock, reset, phase_ff == PH_IDLE, delay_ff == '0, "idle with delay pending")
   `I2CB_ASSERT_IMPLIES(a_busy_has_delay, clock, reset, phase_ff != PH_IDLE, delay_ff != '0, "busy with zero delay")
   `I2CB_ASSERT_IMPLIES(a_read_sda_input, clock, reset, phase_ff == PH_RH || phase_ff == PH_RL || phase_ff == PH_KH || phase_ff == PH_KL, !sda_dir_ff, "SDA driven while reading")

endmodule

`default_nettype wire

// ----- sim/i2c_line_checker.sv -----
// Checker for the I2C master bit engine: mirrors the line sequencer tick by tick
// and compares every response against its prediction. Depends on i2cb_pkg.
`default_nettype none

module i2c_line_checker
   import i2cb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_write_data,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic                 req_cmd_valid,
   input  wire logic [2:0]           req_opcode,
   input  wire logic [BYTE_BITS-1:0] req_write_byte,
   input  wire logic                 req_ack_bit,
   input  wire logic                 req_sda_sample,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic                 rsp_scl_level,
   input  wire logic                 rsp_sda_level,
   input  wire logic                 rsp_sda_output_enable,
   input  wire logic                 rsp_busy_res,
   input  wire logic                 rsp_done_res,
   input  wire logic [BYTE_BITS-1:0] rsp_read_byte,
   input  wire logic                 rsp_ack_seen,
   output int                        fail_count,
   output int                        waiting_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic                 scl;
      logic                 sda;
      logic                 oe;
      logic                 busy;
      logic                 done;
      logic [BYTE_BITS-1:0] rd_byte;
      logic                 ack;
   } line_view_type;

   // mirrored engine state
   phase_type            line_phase;
   logic [2:0]           line_cmd;
   delay_type            wait_left;
   logic [3:0]           bits_done;
   logic [BYTE_BITS-1:0] shifter;
   logic                 drive_scl;
   logic                 drive_sda;
   logic                 drive_oe;
   logic                 last_ack;
   logic [BYTE_BITS-1:0] last_read;
   logic [CSR_WIDTH-1:0] cfg_bit_delay;
   logic [CSR_WIDTH-1:0] cfg_read_delay;
   logic [CSR_WIDTH-1:0] cfg_ack_delay;

   line_view_type expected_views[$];
   line_view_type fresh_view;
   line_view_type oldest_view;
   int            fail_total = 0;

   initial begin
      fail_count    = 0;
      waiting_count = 0;
   end

   task automatic flag(input string msg);
      if (fail_total < PRINT_CAP) begin
         $display("[%0t] %s", $time, msg);
      end
      fail_total++;
   endtask

   task automatic compare_field(input string name, input logic [BYTE_BITS-1:0] got,
                                input logic [BYTE_BITS-1:0] want);
      if (got !== want) begin
         flag($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
      end
   endtask

   // Load the wait counter; the counter is as wide as the register, so only
   // a zero needs fixing up (it counts as one tick).
   function automatic void arm(input phase_type next_phase, input logic [CSR_WIDTH-1:0] ticks);
      line_phase = next_phase;
      wait_left  = (ticks == '0) ? delay_type'(1) : delay_type'(ticks);
   endfunction

   // One tick of the line sequencer; returns the drive levels after the tick.
   function automatic line_view_type next_line_view(input logic cmd, input logic [2:0] op,
                                                    input logic [BYTE_BITS-1:0] wb,
                                                    input logic ab, input logic sda_in);
      line_view_type view;
      logic          finished;
      finished = 1'b0;
      if (line_phase == PH_IDLE) begin
         if (cmd) begin
            line_cmd  = op;
            bits_done = '0;
            case (op)
               OP_START: begin
                  drive_scl = 1'b1; drive_sda = 1'b1; drive_oe = 1'b1;
                  arm(PH_S1, cfg_bit_delay);
               end
               OP_STOP: begin
                  drive_scl = 1'b0; drive_sda = 1'b0; drive_oe = 1'b1;
                  arm(PH_P1, cfg_bit_delay);
               end
               OP_WRITE: begin
                  drive_scl = 1'b0; drive_oe = 1'b1; shifter = wb;
                  arm(PH_WD, cfg_bit_delay);
               end
               OP_READ: begin
                  drive_oe = 1'b0; drive_scl = 1'b0; shifter = '0;
                  arm(PH_RH, cfg_read_delay);
               end
               OP_SEND_ACK: begin
                  drive_scl = 1'b0; drive_sda = ab; drive_oe = 1'b1;
                  arm(PH_AH, CSR_WIDTH'(1));
               end
               OP_RECV_ACK: begin
                  drive_oe = 1'b0; drive_scl = 1'b0;
                  arm(PH_KH, cfg_read_delay);
               end
               default: ;
            endcase
         end
      end else if (wait_left > 1) begin
         wait_left--;
      end else begin
         case (line_phase)
            PH_S1: begin drive_sda = 1'b0; arm(PH_S2, cfg_bit_delay); end
            PH_S2: begin
               drive_scl  = 1'b0;
               line_phase = PH_IDLE;
               wait_left  = '0;
               finished   = 1'b1;
            end
            PH_P1: begin drive_scl = 1'b1; arm(PH_P2, cfg_bit_delay); end
            PH_P2: begin drive_sda = 1'b1; arm(PH_FIN, cfg_bit_delay); end
            PH_WD: begin drive_sda = shifter[BYTE_BITS-1]; arm(PH_WH, cfg_bit_delay); end
            PH_WH: begin drive_scl = 1'b1; arm(PH_WL, cfg_bit_delay); end
            PH_WL: begin
               drive_scl = 1'b0;
               shifter   = shifter << 1;
               bits_done = bits_done + 4'd1;
               if (bits_done >= BYTE_BITS) arm(PH_FIN, cfg_bit_delay);
               else arm(PH_WD, cfg_bit_delay);
            end
            PH_RH: begin
               drive_scl = 1'b1;
               shifter   = {shifter[BYTE_BITS-2:0], sda_in};
               arm(PH_RL, CSR_WIDTH'(1));
            end
            PH_RL: begin
               drive_scl = 1'b0;
               bits_done = bits_done + 4'd1;
               if (bits_done >= BYTE_BITS) arm(PH_END, cfg_read_delay);
               else arm(PH_RH, cfg_read_delay);
            end
            PH_AH: begin drive_scl = 1'b1; arm(PH_AL, cfg_ack_delay); end
            PH_AL: begin drive_scl = 1'b0; arm(PH_FIN, cfg_ack_delay); end
            PH_KH: begin drive_scl = 1'b1; last_ack = sda_in; arm(PH_KL, CSR_WIDTH'(1)); end
            PH_KL: begin drive_scl = 1'b0; arm(PH_END, cfg_read_delay); end
            PH_END: begin drive_oe = 1'b1; arm(PH_FIN, cfg_read_delay); end
            default: begin
               // closing wait over: latch the assembled byte for a read
               if (line_cmd == OP_READ) last_read = shifter;
               line_phase = PH_IDLE;
               wait_left  = '0;
               finished   = 1'b1;
            end
         endcase
      end
      view.scl     = drive_scl;
      view.sda     = drive_sda;
      view.oe      = drive_oe;
      view.busy    = (line_phase != PH_IDLE);
      view.done    = finished;
      view.rd_byte = last_read;
      view.ack     = last_ack;
      return view;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         line_phase     = PH_IDLE;
         line_cmd       = '0;
         wait_left      = '0;
         bits_done      = '0;
         shifter        = '0;
         drive_scl      = 1'b1;
         drive_sda      = 1'b1;
         drive_oe       = 1'b1;
         last_ack       = 1'b1;
         last_read      = '0;
         cfg_bit_delay  = BIT_DELAY_RESET;
         cfg_read_delay = READ_DELAY_RESET;
         cfg_ack_delay  = ACK_DELAY_RESET;
         expected_views.delete();
      end else begin
         if (req_valid && req_ready) begin
            fresh_view = next_line_view(req_cmd_valid, req_opcode, req_write_byte,
                                        req_ack_bit, req_sda_sample);
            expected_views.push_back(fresh_view);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               flag("response transaction with nothing outstanding");
            end else begin
               oldest_view = expected_views.pop_front();
               compare_field("scl_level", rsp_scl_level, oldest_view.scl);
               compare_field("sda_level", rsp_sda_level, oldest_view.sda);
               compare_field("sda_output_enable", rsp_sda_output_enable, oldest_view.oe);
               compare_field("busy_res", rsp_busy_res, oldest_view.busy);
               compare_field("done_res", rsp_done_res, oldest_view.done);
               compare_field("read_byte", rsp_read_byte, oldest_view.rd_byte);
               compare_field("ack_seen", rsp_ack_seen, oldest_view.ack);
            end
         end
         // a register write takes effect for the ticks after this edge
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BIT_DELAY:  cfg_bit_delay  = csr_write_data;
               CSR_READ_DELAY: cfg_read_delay = csr_write_data;
               CSR_ACK_DELAY:  cfg_ack_delay  = csr_write_data;
               default: ;
            endcase
         end
      end
      waiting_count <= expected_views.size();
      fail_count    <= fail_total;
   end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Top of the I2C master bit engine testbench: clock, reset, stimulus and verdict.
// Depends on i2cb_pkg, i2c_master_bit_engine_core and i2c_line_checker.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cb_pkg::*;

   // Cycles the receiver holds off in one go while the sender keeps offering.
   localparam int HOLD_OFF_CYCLES = 300;
   // Cycles with no transaction on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 20000;
   // Random ticks per idling phase; four phases give about 600, the directed
   // part brings the run to roughly 850.
   localparam int TICKS_PER_PHASE = 130;
   localparam int SETTLE_CYCLES = 4;
   localparam int NOISE_PCT = 10;
   // The index beyond the last register: writes to it must be dropped.
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;
   // Opcodes with no command behind them.
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef enum {SDA_LOW, SDA_RELEASED, SDA_RANDOM} sda_drive_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_cmd_valid = 1'b0;
   logic [2:0]           req_opcode = '0;
   logic [BYTE_BITS-1:0] req_write_byte = '0;
   logic                 req_ack_bit = 1'b0;
   logic                 req_sda_sample = 1'b0;
   logic                 rsp_ready = 1'b0;
   wire logic            req_ready;
   wire logic            rsp_valid;
   wire logic            rsp_scl_level;
   wire logic            rsp_sda_level;
   wire logic            rsp_sda_output_enable;
   wire logic            rsp_busy_res;
   wire logic            rsp_done_res;
   wire logic [BYTE_BITS-1:0] rsp_read_byte;
   wire logic            rsp_ack_seen;
   int                   fail_count;
   int                   waiting_count;

   // Stimulus knobs, changed between phases.
   int         req_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         busy_noise_pct = NOISE_PCT;
   bit         hold_off_request = 1'b0;
   int         tick_count = 0;
   logic [CSR_WIDTH-1:0] bit_delay_now = BIT_DELAY_RESET;
   logic [CSR_WIDTH-1:0] read_delay_now = READ_DELAY_RESET;
   logic [CSR_WIDTH-1:0] ack_delay_now = ACK_DELAY_RESET;

   int         quiet_cycles = 0;

   i2c_master_bit_engine_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd_valid         (req_cmd_valid),
      .req_opcode            (req_opcode),
      .req_write_byte        (req_write_byte),
      .req_ack_bit           (req_ack_bit),
      .req_sda_sample        (req_sda_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_scl_level         (rsp_scl_level),
      .rsp_sda_level         (rsp_sda_level),
      .rsp_sda_output_enable (rsp_sda_output_enable),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_read_byte         (rsp_read_byte),
      .rsp_ack_seen          (rsp_ack_seen)
   );

   i2c_line_checker checker_inst (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd_valid         (req_cmd_valid),
      .req_opcode            (req_opcode),
      .req_write_byte        (req_write_byte),
      .req_ack_bit           (req_ack_bit),
      .req_sda_sample        (req_sda_sample),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_scl_level         (rsp_scl_level),
      .rsp_sda_level         (rsp_sda_level),
      .rsp_sda_output_enable (rsp_sda_output_enable),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_read_byte         (rsp_read_byte),
      .rsp_ack_seen          (rsp_ack_seen),
      .fail_count            (fail_count),
      .waiting_count         (waiting_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abandon the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: stall at random, or hold off for a long stretch on request
   // so that the response register fills and the engine stops taking ticks.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one tick and hold it until accepted. Valid is only dropped when the
   // sender decides to idle, never between two back-to-back transactions.
   task automatic present_tick(input logic cmd, input logic [2:0] op,
                               input logic [BYTE_BITS-1:0] wb, input logic ab,
                               input logic sda);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd_valid  <= cmd;
      req_opcode     <= op;
      req_write_byte <= wb;
      req_ack_bit    <= ab;
      req_sda_sample <= sda;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tick_count++;
   endtask

   // Ticks a command occupies from the tick that carries it to its done pulse,
   // under the delays currently loaded (a zero delay counts as one tick).
   function automatic int command_ticks(input logic [2:0] op);
      int b;
      int r;
      int a;
      b = (bit_delay_now == '0) ? 1 : int'(bit_delay_now);
      r = (read_delay_now == '0) ? 1 : int'(read_delay_now);
      a = (ack_delay_now == '0) ? 1 : int'(ack_delay_now);
      case (op)
         OP_START:    return 1 + 2 * b;
         OP_STOP:     return 1 + 3 * b;
         // three waits per bit, then the closing wait
         OP_WRITE:    return 1 + (3 * BYTE_BITS + 1) * b;
         // per bit a low wait and a single high tick, then two closing waits
         OP_READ:     return 1 + BYTE_BITS * (r + 1) + 2 * r;
         OP_SEND_ACK: return 2 + 2 * a;
         OP_RECV_ACK: return 2 + 3 * r;
         default:     return 1;
      endcase
   endfunction

   // Issue a command on an idle engine and tick it through to completion.
   // Some busy ticks carry a further command, which the engine must drop.
   task automatic run_command(input logic [2:0] op, input logic [BYTE_BITS-1:0] wb,
                              input logic ab, input sda_drive_type mode);
      int   span;
      logic sda;
      span = command_ticks(op);
      for (int i = 0; i < span; i++) begin
         case (mode)
            SDA_LOW:      sda = 1'b0;
            SDA_RELEASED: sda = 1'b1;
            default:      sda = 1'($urandom_range(0, 1));
         endcase
         if (i == 0) begin
            present_tick(1'b1, op, wb, ab, sda);
         end else begin
            present_tick(($urandom_range(0, 99) < busy_noise_pct), 3'($urandom),
                         BYTE_BITS'($urandom), 1'($urandom), sda);
         end
      end
   endtask

   // Drop valid and wait until every response is back and the engine is quiet.
   task automatic settle;
      req_valid <= 1'b0;
      do @(posedge clock); while (waiting_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Load all three delays plus a write to the unused index, which is dropped.
   task automatic load_delays(input logic [CSR_WIDTH-1:0] b, input logic [CSR_WIDTH-1:0] r,
                              input logic [CSR_WIDTH-1:0] a);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BIT_DELAY;
      csr_write_data   <= b;
      @(posedge clock);
      csr_index      <= CSR_READ_DELAY;
      csr_write_data <= r;
      @(posedge clock);
      csr_index      <= CSR_ACK_DELAY;
      csr_write_data <= a;
      @(posedge clock);
      csr_index      <= CSR_SPARE_INDEX;
      csr_write_data <= CSR_WIDTH'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      bit_delay_now  = b;
      read_delay_now = r;
      ack_delay_now  = a;
   endtask

   initial begin
      logic [2:0] op;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset delays. The first command is hammered with further
      // commands on every busy tick; all of them must be dropped.
      busy_noise_pct = 100;
      run_command(OP_START, '0, 1'b0, SDA_RANDOM);
      busy_noise_pct = NOISE_PCT;
      run_command(OP_SEND_ACK, '0, 1'b0, SDA_RANDOM);
      run_command(OP_STOP, '0, 1'b0, SDA_RANDOM);
      // unused opcodes leave the engine idle
      run_command(OP_SPARE_LO, 8'h5A, 1'b1, SDA_RANDOM);
      run_command(OP_SPARE_HI, 8'hA5, 1'b0, SDA_RANDOM);
      settle();

      // Short delays: data commands with fixed line levels.
      load_delays(CSR_WIDTH'(1), CSR_WIDTH'(2), CSR_WIDTH'(1));
      run_command(OP_WRITE, 8'hFF, 1'b0, SDA_RANDOM);
      run_command(OP_RECV_ACK, '0, 1'b0, SDA_LOW);
      run_command(OP_WRITE, 8'h00, 1'b1, SDA_RANDOM);
      run_command(OP_RECV_ACK, '0, 1'b0, SDA_RELEASED);
      run_command(OP_READ, '0, 1'b0, SDA_RELEASED);
      run_command(OP_SEND_ACK, '0, 1'b0, SDA_RANDOM);
      run_command(OP_READ, '0, 1'b0, SDA_LOW);
      run_command(OP_SEND_ACK, '0, 1'b1, SDA_RANDOM);
      run_command(OP_STOP, '0, 1'b0, SDA_RANDOM);
      settle();

      // Zero in every delay register: each wait shrinks to a single tick.
      load_delays('0, '0, '0);
      run_command(OP_START, '0, 1'b0, SDA_RANDOM);
      run_command(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
      run_command(OP_READ, '0, 1'b0, SDA_RANDOM);
      run_command(OP_SEND_ACK, '0, 1'b1, SDA_RANDOM);
      run_command(OP_RECV_ACK, '0, 1'b0, SDA_RANDOM);
      run_command(OP_STOP, '0, 1'b0, SDA_RANDOM);
      settle();

      // Random: back-to-back commands with random content under small delays,
      // a sprinkling of unused opcodes and idle ticks, across idling phases.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               req_idle_pct     = 0;
               rsp_stall_pct    = 0;
               hold_off_request = 1'b1;
            end
            1: begin req_idle_pct = 76; rsp_stall_pct = 0; end
            2: begin req_idle_pct = 0; rsp_stall_pct = 76; end
            default: begin req_idle_pct = 38; rsp_stall_pct = 38; end
         endcase
         load_delays(CSR_WIDTH'($urandom_range(0, 3)), CSR_WIDTH'($urandom_range(0, 3)),
                     CSR_WIDTH'($urandom_range(0, 3)));
         tick_count = 0;
         while (tick_count < TICKS_PER_PHASE) begin
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  present_tick(1'b0, 3'($urandom), BYTE_BITS'($urandom), 1'($urandom),
                               1'($urandom));
               end
            end
            if ($urandom_range(0, 9) == 0) begin
               op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end else begin
               op = 3'($urandom_range(OP_START, OP_RECV_ACK));
            end
            run_command(op, BYTE_BITS'($urandom), 1'($urandom), SDA_RANDOM);
         end
         settle();
      end

      if (fail_count == 0 && waiting_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
